// ===== rtl/csrq_pkg.sv =====
package csrq_pkg;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_DONE   = 2'd2,
		OP_LOOKUP = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_NONE = 2'd2
	} status_code_t;

	typedef enum logic [1:0] {
		SLOT_FREE = 2'd0,
		SLOT_WAIT = 2'd1,
		SLOT_DONE = 2'd2
	} slot_state_t;

	localparam int DEPTH_W = 5;

	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] resource_id;
		logic [7:0] command_id;
		logic [7:0] length;
		logic       release_when_done;
	} in_item_t;

	typedef struct packed {
		status_code_t status_code;
		logic [3:0]   slot_index;
		logic [7:0]   slot_resource;
		logic [7:0]   slot_command;
		logic [7:0]   slot_length;
		slot_state_t  slot_state;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic next_scan;
		logic commit;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_more;
	} dp_stat_t;

endpackage

// ===== rtl/csrq_ctrl.sv =====
module csrq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  csrq_pkg::dp_stat_t stat,
	output csrq_pkg::dp_cmd_t  cmd
);
	import csrq_pkg::*;

	typedef enum logic {
		IDLE,
		EVAL
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load      = (state_q == IDLE) && in_valid;
		cmd.next_scan = (state_q == EVAL) && stat.scan_more;
		// The slot update and the result load happen together, once the
		// output register can take the result.
		cmd.commit    = (state_q == EVAL) && !stat.scan_more && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= EVAL;
					end
				end
				EVAL: begin
					if (!stat.scan_more && out_free) begin
						state_q <= IDLE;
					end
				end
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/csrq_datapath.sv =====
module csrq_datapath #(
	parameter int SLOTS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [csrq_pkg::DEPTH_W-1:0]      depth,
	input  csrq_pkg::in_item_t                item,
	input  csrq_pkg::dp_cmd_t                 cmd,
	output csrq_pkg::dp_stat_t                stat,
	output csrq_pkg::out_item_t               result
);
	import csrq_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = (IW + 1 > DEPTH_W) ? IW + 1 : DEPTH_W;

	slot_state_t status_q [SLOTS];
	logic        mark_q   [SLOTS];
	logic [7:0]  res_mem  [SLOTS];
	logic [7:0]  cmd_mem  [SLOTS];
	logic [7:0]  len_mem  [SLOTS];

	logic [IW-1:0] wptr_q;
	logic [IW-1:0] rptr_q;
	logic [IW-1:0] addr_q;
	logic [IW-1:0] rd_addr;
	logic [7:0]    res_rd_q;
	logic [7:0]    cmd_rd_q;
	logic [7:0]    len_rd_q;

	opcode_t     op_q;
	logic [7:0]  res_q;
	logic [7:0]  cmdid_q;
	logic [7:0]  len_q;
	logic        rel_q;

	logic [CW-1:0] eff;
	logic [CW-1:0] addr_inc;
	slot_state_t   st;
	logic          usable;
	logic          hit;
	logic          write_ok;
	out_item_t     res_d;
	out_item_t     out_q;

	function automatic logic [IW-1:0] advance(input logic [IW-1:0] p,
			input logic [CW-1:0] d);
		logic [CW-1:0] n;
		n = CW'(p) + CW'(1);
		return (n >= d) ? '0 : n[IW-1:0];
	endfunction

	// A depth of zero acts as one; a depth beyond the ring acts as the ring.
	always_comb begin
		if (depth == '0) begin
			eff = CW'(1);
		end else if (CW'(depth) > CW'(SLOTS)) begin
			eff = CW'(SLOTS);
		end else begin
			eff = CW'(depth);
		end
	end

	assign addr_inc = CW'(addr_q) + CW'(1);
	assign st       = status_q[addr_q];
	assign usable   = (st == SLOT_FREE) || ((st == SLOT_DONE) && mark_q[addr_q]);
	assign hit      = (st != SLOT_FREE) && (cmd_rd_q == cmdid_q);
	assign write_ok = (op_q == OP_WRITE) && usable;

	assign stat.scan_more = (op_q == OP_LOOKUP) && !hit && (addr_inc < eff);

	always_comb begin
		if (cmd.load) begin
			unique case (item.opcode)
				OP_WRITE:          rd_addr = wptr_q;
				OP_READ, OP_DONE:  rd_addr = rptr_q;
				OP_LOOKUP:         rd_addr = '0;
			endcase
		end else begin
			rd_addr = addr_inc[IW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= item.opcode;
			res_q   <= item.resource_id;
			cmdid_q <= item.command_id;
			len_q   <= item.length;
			rel_q   <= item.release_when_done;
		end
		if (cmd.load || cmd.next_scan) begin
			addr_q   <= rd_addr;
			res_rd_q <= res_mem[rd_addr];
			cmd_rd_q <= cmd_mem[rd_addr];
			len_rd_q <= len_mem[rd_addr];
		end
		if (cmd.commit && write_ok) begin
			res_mem[addr_q] <= res_q;
			cmd_mem[addr_q] <= cmdid_q;
			len_mem[addr_q] <= len_q;
		end
		if (cmd.commit) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				status_q[i] <= SLOT_FREE;
				mark_q[i]   <= 1'b0;
			end
			wptr_q <= '0;
			rptr_q <= '0;
		end else if (cmd.commit) begin
			unique case (op_q)
				OP_WRITE: begin
					if (usable) begin
						status_q[addr_q] <= SLOT_WAIT;
						mark_q[addr_q]   <= rel_q;
						wptr_q           <= advance(addr_q, eff);
					end
				end
				OP_DONE: begin
					status_q[addr_q] <= SLOT_DONE;
					rptr_q           <= advance(addr_q, eff);
				end
				OP_READ, OP_LOOKUP: begin
				end
			endcase
		end
	end

	always_comb begin
		res_d.status_code   = STAT_OK;
		res_d.slot_index    = 4'(addr_q);
		res_d.slot_resource = res_rd_q;
		res_d.slot_command  = cmd_rd_q;
		res_d.slot_length   = len_rd_q;
		res_d.slot_state    = st;
		unique case (op_q)
			OP_WRITE: begin
				if (usable) begin
					res_d.slot_resource = res_q;
					res_d.slot_command  = cmdid_q;
					res_d.slot_length   = len_q;
					res_d.slot_state    = SLOT_WAIT;
				end else begin
					res_d.status_code = STAT_FULL;
				end
			end
			OP_READ: begin
				if (st != SLOT_WAIT) begin
					res_d.status_code   = STAT_NONE;
					res_d.slot_resource = '0;
					res_d.slot_command  = '0;
					res_d.slot_length   = '0;
				end
			end
			OP_DONE: begin
				res_d.slot_state = SLOT_DONE;
			end
			OP_LOOKUP: begin
				if (!hit) begin
					res_d.status_code   = STAT_NONE;
					res_d.slot_index    = '0;
					res_d.slot_resource = '0;
					res_d.slot_command  = '0;
					res_d.slot_length   = '0;
					res_d.slot_state    = SLOT_FREE;
				end
			end
		endcase
	end

	assign result = out_q;

`ifndef SYNTHESIS
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(IW'(SLOTS - 1) >= wptr_q) && (IW'(SLOTS - 1) >= rptr_q))
		else $error("ring pointer beyond the last slot");

	a_scan_only_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.next_scan |-> (op_q == OP_LOOKUP) && !cmd.commit && !cmd.load)
		else $error("scan step outside a lookup");

	a_write_marks_wait: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && write_ok |=> status_q[$past(addr_q)] == SLOT_WAIT)
		else $error("written slot not waiting");

	a_done_marks_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && (op_q == OP_DONE) |=> status_q[$past(addr_q)] == SLOT_DONE)
		else $error("completed slot not done");
`endif

endmodule

// ===== rtl/command_slot_ring_queue.sv =====
// Command slot ring queue.
// Items enter on the s_ stream: s_tuser carries the opcode (write, read head,
// mark head done, lookup) and s_tdata the slot contents for a write or the
// command id for a lookup. Every item gives exactly one result item on the
// m_ stream, with the status code in m_tuser and the reported slot in m_tdata.
// The APB port holds depth_in_use at address 0; write it only while idle.
// Write, read and done are accepted in a cycle that also reads the slot's
// stored contents; the slot update and the output register load follow,
// once that register can take the result. A lookup scans the slots in use
// one per cycle through the same memory read port, stopping at the first
// match or after the last slot in use.
// Reset frees every slot, clears the release marks and both pointers and sets
// the depth to 16; stored contents are not cleared.
// While the receiver stalls, the result stays in the output register; one
// more item is accepted and worked on, and it waits until that register
// frees before its slot update and result take effect.
module command_slot_ring_queue #(
	parameter int SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// resource_id[7:0], command_id[15:8], length[23:16],
	// release_when_done[24], zero[31:25]
	input  logic [31:0] s_tdata,
	// opcode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// slot_index[3:0], slot_resource[11:4], slot_command[19:12],
	// slot_length[27:20], slot_state[29:28], zero[31:30]
	output logic [31:0] m_tdata,
	// status_code[1:0]
	output logic [1:0]  m_tuser,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import csrq_pkg::*;

	localparam logic REG_DEPTH = 1'b0;

	logic [DEPTH_W-1:0] depth_q;
	in_item_t           item;
	out_item_t          result;
	dp_cmd_t            cmd;
	dp_stat_t           stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DEPTH) ? 32'(depth_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_W'(16);
		end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEPTH)) begin
			depth_q <= pwdata[DEPTH_W-1:0];
		end
	end

	always_comb begin
		item.opcode            = opcode_t'(s_tuser);
		item.resource_id       = s_tdata[7:0];
		item.command_id        = s_tdata[15:8];
		item.length            = s_tdata[23:16];
		item.release_when_done = s_tdata[24];
	end

	csrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	csrq_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.depth  (depth_q),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

	assign m_tuser = result.status_code;
	assign m_tdata = {2'b00, result.slot_state, result.slot_length,
		result.slot_command, result.slot_resource, result.slot_index};

endmodule

// ===== verif/command_slot_ring_queue_tb.sv =====
`timescale 1ns / 1ps

module command_slot_ring_queue_tb;
	import csrq_pkg::*;

	localparam int RING_SLOTS = 16;
	localparam logic [2:0] DEPTH_ADDR = 3'd0;
	localparam int SETTLE_CYCLES = 24;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// resource_id[7:0], command_id[15:8], length[23:16],
	// release_when_done[24], zero[31:25]
	logic [31:0] s_tdata = '0;
	// opcode[1:0]
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// slot_index[3:0], slot_resource[11:4], slot_command[19:12],
	// slot_length[27:20], slot_state[29:28], zero[31:30]
	logic [31:0] m_tdata;
	// status_code[1:0]
	logic [1:0]  m_tuser;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	command_slot_ring_queue DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Shadow copy of the ring, updated as each command item is accepted.
	slot_state_t        slot_st [RING_SLOTS];
	logic               slot_rel [RING_SLOTS];
	logic [7:0]         slot_res [RING_SLOTS];
	logic [7:0]         slot_cmd [RING_SLOTS];
	logic [7:0]         slot_len [RING_SLOTS];
	bit                 slot_written [RING_SLOTS];
	int                 wr_ptr = 0;
	int                 rd_ptr = 0;
	logic [DEPTH_W-1:0] depth_reg = 5'd16;

	in_item_t  cmd_backlog [$];
	out_item_t expected_replies [$];
	in_item_t  next_cmd;
	in_item_t  taken_cmd;
	out_item_t want_reply;
	out_item_t got_reply;

	bit in_fire = 1'b0;
	bit no_gaps = 1'b0;
	bit long_hold_req = 1'b0;
	int tx_gap = 0;
	int hold_left = 0;
	int stall_left = 0;
	int cycle_count = 0;

	int mismatches = 0;
	int cmds_accepted = 0;
	int replies_checked = 0;
	int full_refusals = 0;
	int lookup_hits = 0;
	int reclaims = 0;

	int unsigned depth_plan [10] = '{16, 1, 3, 0, 5, 8, 31, 17, 2, 16};

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int ring_depth();
		if (depth_reg == 0)
			return 1;
		if (depth_reg > RING_SLOTS)
			return RING_SLOTS;
		return int'(depth_reg);
	endfunction

	function automatic int next_slot(input int p);
		return (p + 1 >= ring_depth()) ? 0 : p + 1;
	endfunction

	function automatic out_item_t slot_report(input status_code_t code, input int idx,
		input bit with_contents);
		out_item_t r;
		r.status_code   = code;
		r.slot_index    = idx[3:0];
		r.slot_resource = with_contents ? slot_res[idx] : 8'd0;
		r.slot_command  = with_contents ? slot_cmd[idx] : 8'd0;
		r.slot_length   = with_contents ? slot_len[idx] : 8'd0;
		r.slot_state    = slot_st[idx];
		return r;
	endfunction

	// Applies one accepted command to the shadow ring and queues its reply.
	function automatic void ring_apply(input in_item_t c);
		out_item_t r;
		int        w;
		int        i;
		bit        hit;
		w = wr_ptr;
		hit = 1'b0;
		case (c.opcode)
			OP_WRITE: begin
				if (slot_st[w] == SLOT_FREE || (slot_st[w] == SLOT_DONE && slot_rel[w])) begin
					if (slot_st[w] == SLOT_DONE)
						reclaims++;
					slot_res[w] = c.resource_id;
					slot_cmd[w] = c.command_id;
					slot_len[w] = c.length;
					slot_rel[w] = c.release_when_done;
					slot_st[w] = SLOT_WAIT;
					slot_written[w] = 1'b1;
					wr_ptr = next_slot(w);
					r = slot_report(STAT_OK, w, 1'b1);
				end else begin
					full_refusals++;
					r = slot_report(STAT_FULL, w, 1'b1);
				end
			end
			OP_READ: begin
				if (slot_st[rd_ptr] == SLOT_WAIT)
					r = slot_report(STAT_OK, rd_ptr, 1'b1);
				else
					r = slot_report(STAT_NONE, rd_ptr, 1'b0);
			end
			OP_DONE: begin
				slot_st[rd_ptr] = SLOT_DONE;
				r = slot_report(STAT_OK, rd_ptr, 1'b1);
				rd_ptr = next_slot(rd_ptr);
			end
			default: begin
				r = '0;
				r.status_code = STAT_NONE;
				r.slot_state = SLOT_FREE;
				for (i = 0; i < ring_depth(); i++) begin
					if (!hit && slot_st[i] != SLOT_FREE && slot_cmd[i] == c.command_id) begin
						r = slot_report(STAT_OK, i, 1'b1);
						hit = 1'b1;
					end
				end
				if (hit)
					lookup_hits++;
			end
		endcase
		expected_replies.push_back(r);
	endfunction

	function automatic void compare_field(input string fname, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
			mismatches++;
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Sender: offers the next command once the previous one has been taken.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (cmd_backlog.size() > 0) begin
				next_cmd = cmd_backlog.pop_front();
				// A done on a slot that was never filled would expose its stale
				// contents, so such an item is sent as a read instead.
				if (next_cmd.opcode == OP_DONE && !slot_written[rd_ptr])
					next_cmd.opcode = OP_READ;
				s_tdata <= {7'd0, next_cmd.release_when_done, next_cmd.length,
					next_cmd.command_id, next_cmd.resource_id};
				s_tuser <= next_cmd.opcode;
				s_tvalid <= 1'b1;
				tx_gap = pick_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got_reply.status_code   = status_code_t'(m_tuser);
				got_reply.slot_index    = m_tdata[3:0];
				got_reply.slot_resource = m_tdata[11:4];
				got_reply.slot_command  = m_tdata[19:12];
				got_reply.slot_length   = m_tdata[27:20];
				got_reply.slot_state    = slot_state_t'(m_tdata[29:28]);
				if (expected_replies.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got %h/%h",
						$time, m_tuser, m_tdata);
					mismatches++;
				end else begin
					want_reply = expected_replies.pop_front();
					compare_field("status_code", want_reply.status_code, got_reply.status_code);
					compare_field("slot_index", want_reply.slot_index, got_reply.slot_index);
					compare_field("slot_resource", want_reply.slot_resource,
						got_reply.slot_resource);
					compare_field("slot_command", want_reply.slot_command,
						got_reply.slot_command);
					compare_field("slot_length", want_reply.slot_length, got_reply.slot_length);
					compare_field("slot_state", want_reply.slot_state, got_reply.slot_state);
					replies_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				taken_cmd.opcode            = opcode_t'(s_tuser);
				taken_cmd.resource_id       = s_tdata[7:0];
				taken_cmd.command_id        = s_tdata[15:8];
				taken_cmd.length            = s_tdata[23:16];
				taken_cmd.release_when_done = s_tdata[24];
				ring_apply(taken_cmd);
				cmds_accepted++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				expected_replies.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic queue_item(input opcode_t op, input logic [7:0] res, input logic [7:0] cmd,
		input logic [7:0] len, input logic rel);
		in_item_t it;
		it.opcode            = op;
		it.resource_id       = res;
		it.command_id        = cmd;
		it.length            = len;
		it.release_when_done = rel;
		cmd_backlog.push_back(it);
	endtask

	// Random commands; command ids mostly come from a small pool so lookups hit.
	task automatic queue_random(input int count, input bit mixed_release);
		int         k;
		int         pick;
		logic [7:0] cid;
		logic       rel;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			cid = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
			rel = mixed_release ? 1'($urandom) : 1'b1;
			if (pick < 35)
				queue_item(OP_WRITE, 8'($urandom), cid, 8'($urandom), rel);
			else if (pick < 55)
				queue_item(OP_READ, 8'($urandom), cid, 8'($urandom), 1'($urandom));
			else if (pick < 80)
				queue_item(OP_DONE, 8'($urandom), cid, 8'($urandom), 1'($urandom));
			else
				queue_item(OP_LOOKUP, 8'($urandom), cid, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic wait_idle();
		while (cmd_backlog.size() > 0 || s_tvalid || expected_replies.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_depth_readback();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= DEPTH_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[DEPTH_W-1:0] !== depth_reg) begin
			$display("%0t: depth_in_use readback mismatch, expected %0d, got %0d", $time,
				depth_reg, prdata[DEPTH_W-1:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_depth(input int unsigned value);
		wait_idle();
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= DEPTH_ADDR;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		depth_reg = value[DEPTH_W-1:0];
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		check_depth_readback();
	endtask

	initial begin
		int ph;
		for (ph = 0; ph < RING_SLOTS; ph++) begin
			slot_st[ph] = SLOT_FREE;
			slot_rel[ph] = 1'b0;
			slot_res[ph] = '0;
			slot_cmd[ph] = '0;
			slot_len[ph] = '0;
			slot_written[ph] = 1'b0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_depth_readback();

		// Field extremes, a hit and a miss on lookup, read of a free slot.
		queue_item(OP_WRITE, 8'h00, 8'h00, 8'h00, 1'b1);
		queue_item(OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		queue_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_LOOKUP, 8'h00, 8'hFF, 8'h00, 1'b0);
		queue_item(OP_LOOKUP, 8'hFF, 8'h5A, 8'hFF, 1'b1);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_LOOKUP, 8'h00, 8'h00, 8'h00, 1'b0);

		// Shrink the ring under both pointers: reclaim of done slots, full,
		// and a lookup that must not see the slot beyond the depth.
		program_depth(2);
		queue_item(OP_WRITE, 8'hA5, 8'h3C, 8'h81, 1'b1);
		queue_item(OP_WRITE, 8'h5A, 8'hC3, 8'h7E, 1'b1);
		queue_item(OP_WRITE, 8'h01, 8'h02, 8'h03, 1'b1);
		queue_item(OP_WRITE, 8'h11, 8'h22, 8'h33, 1'b1);
		queue_item(OP_LOOKUP, 8'h00, 8'h3C, 8'h00, 1'b0);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0);

		// A depth of zero behaves as a single slot.
		program_depth(0);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_WRITE, 8'h77, 8'h02, 8'h88, 1'b1);
		queue_item(OP_WRITE, 8'h99, 8'h04, 8'hAA, 1'b1);
		queue_item(OP_READ, 8'h00, 8'h00, 8'h00, 1'b0);
		queue_item(OP_DONE, 8'h00, 8'h00, 8'h00, 1'b0);

		program_depth(31);
		queue_item(OP_LOOKUP, 8'h00, 8'h02, 8'h00, 1'b0);

		// Slots are only reclaimed when the release mark is set, so commands
		// without it are kept to the last phase, where they jam the ring.
		for (ph = 0; ph < 10; ph++) begin
			program_depth(depth_plan[ph]);
			no_gaps = (ph == 4);
			queue_random(110, 1'b0);
			if (ph == 0)
				long_hold_req = 1'b1;
		end
		program_depth(4);
		no_gaps = 1'b0;
		queue_random(60, 1'b1);
		wait_idle();

		$display("Run covered %0d command items and %0d checked results over %0d depths.",
			cmds_accepted, replies_checked, 14);
		$display("Seen: %0d full refusals, %0d reclaimed done slots, %0d lookup hits.",
			full_refusals, reclaims, lookup_hits);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
